// ----- hdl/tprs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and codes for the thermal profile ramp sequencer.
// No dependencies; every other file but tprs_ram imports this package.
package tprs_pkg;

  localparam int OP_W       = 2;
  localparam int TEMP_W     = 15;
  localparam int IDX_W      = 4;
  localparam int KIND_W     = 2;
  localparam int ETEMP_W    = 10;
  localparam int SECS_W     = 8;
  localparam int TGT_W      = 14;
  localparam int ELAPSED_W  = 9;

  localparam int DEPTH_DEF     = 16;
  localparam int RATE_FRAC_DEF = 12;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NORMAL   = 2'd0,
    KIND_COOL_OFF = 2'd1,
    KIND_COOL_ON  = 2'd2,
    KIND_DONE     = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [ETEMP_W-1:0]   temp;
    logic [SECS_W-1:0]    secs;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- hdl/tprs_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sequencer's input and result words.
// Depends on tprs_pkg for the field widths.
interface tprs_in_if import tprs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [TEMP_W-1:0] temperature;
  logic [IDX_W-1:0]         entry_index;
  logic [KIND_W-1:0]        entry_kind;
  logic [ETEMP_W-1:0]       entry_temp;
  logic [SECS_W-1:0]        entry_seconds;

  modport source (output valid, operation, temperature, entry_index, entry_kind,
                  entry_temp, entry_seconds, input ready);
  modport sink   (input valid, operation, temperature, entry_index, entry_kind,
                  entry_temp, entry_seconds, output ready);
endinterface

interface tprs_out_if import tprs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] setpoint_out;
  logic [TGT_W-1:0]         target_out;
  logic                     cooler_on;
  logic                     running;
  logic                     finished;

  modport source (output valid, setpoint_out, target_out, cooler_on, running, finished,
                  input ready);
  modport sink   (input valid, setpoint_out, target_out, cooler_on, running, finished,
                  output ready);
endinterface

// ----- hdl/thermal_profile_ramp_sequencer_top.sv -----
`timescale 1ns / 1ps
// Thermal profile ramp sequencer: profile table, step walker and setpoint ramp.
// A write goes from IDLE to RESP; a tick without advance passes RD and EVAL first;
// a table walk adds an RD and EVAL pass per slot visited (one RAM read each), and a
// new ramp rate waits in DIV for the serial divider. One word in flight at a time;
// the next word is taken while the last result waits. Synchronous reset clears the
// control and ramp state but not scan, mode or held words; table unset until written.
module thermal_profile_ramp_sequencer_top import tprs_pkg::*; #(
  parameter int TABLE_DEPTH    = DEPTH_DEF,
  parameter int RATE_FRAC_BITS = RATE_FRAC_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tprs_in_if.sink    in_ch,
  tprs_out_if.source out_ch
);

  localparam int F      = RATE_FRAC_BITS;
  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int IW     = $clog2(TABLE_DEPTH + 1);
  localparam int ACC_W  = TEMP_W + F;
  localparam int RATE_W = TEMP_W + 1 + F;
  localparam int SUM_W  = RATE_W + 1;
  localparam logic [IW-1:0] LAST_IDX  = IW'(TABLE_DEPTH - 1);
  localparam logic [IW-1:0] DEPTH_IDX = IW'(TABLE_DEPTH);
  localparam logic signed [SUM_W-1:0] ACC_HI = {2'b00, 15'h3FFF, {F{1'b0}}};
  localparam logic signed [SUM_W-1:0] ACC_LO = {2'b11, 15'h4000, {F{1'b0}}};

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD   = 5'b00010,
    ST_EVAL = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_RESP = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_ADV   = 2'd1,
    MODE_CUR   = 2'd2
  } mode_t;

  state_t                    state_r, state_nxt;
  mode_t                     mode_r, mode_nxt;
  logic signed [TEMP_W-1:0]  temp_r;
  logic [IW-1:0]             scan_r, scan_nxt;
  logic [IW-1:0]             step_r, step_nxt;
  logic [ETEMP_W-1:0]        target_r, target_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [RATE_W-1:0]  rate_r, rate_nxt;
  logic [ELAPSED_W-1:0]      elapsed_r, elapsed_nxt;
  logic                      cooler_r, cooler_nxt;
  logic                      active_r, active_nxt;
  logic                      fin_r, fin_nxt;

  logic                      out_valid_r;
  logic signed [TEMP_W-1:0]  out_sp_r;
  logic [TGT_W-1:0]          out_tgt_r;
  logic                      out_cool_r;
  logic                      out_run_r;
  logic                      out_fin_r;

  logic                      in_acc;
  logic                      out_load;
  logic                      ram_we;
  logic [ENTRY_W-1:0]        ram_rdata;
  entry_t                    ent;
  entry_t                    wr_ent;

  logic                      div_start;
  logic                      div_neg;
  logic [ACC_W-1:0]          div_mag;
  logic                      div_done;
  logic signed [RATE_W-1:0]  div_quot;

  logic [IW-1:0]             step_inc;
  logic signed [TEMP_W+1:0]  diff;
  logic [TEMP_W+1:0]         diff_abs;
  logic signed [SUM_W-1:0]   sum;
  logic                      reached;
  logic [ELAPSED_W-1:0]      elapsed_inc;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == ST_RESP) && (!out_valid_r || out_ch.ready);

  assign wr_ent = '{kind: kind_t'(in_ch.entry_kind), temp: in_ch.entry_temp,
                    secs: in_ch.entry_seconds};
  assign ram_we = in_acc && (op_t'(in_ch.operation) == OP_WRITE) &&
                  ({{(32-IDX_W){1'b0}}, in_ch.entry_index} < TABLE_DEPTH);

  tprs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_ch.entry_index)),
    .wdata (wr_ent),
    .raddr (scan_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign ent = entry_t'(ram_rdata);

  tprs_div #(
    .FRAC_BITS (F)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .negate   (div_neg),
    .mag      (div_mag),
    .divisor  (ent.secs),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    step_inc    = step_r + IW'(1);
    diff        = $signed({3'b000, ent.temp, 4'b0000}) - $signed({{2{temp_r[TEMP_W-1]}}, temp_r});
    diff_abs    = diff[TEMP_W+1] ? ((TEMP_W+2)'(0) - diff) : diff;
    sum         = $signed({{2{acc_r[ACC_W-1]}}, acc_r}) + $signed({rate_r[RATE_W-1], rate_r});
    elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + ELAPSED_W'(1);
    if (!rate_r[RATE_W-1]) begin
      reached = $signed({temp_r[TEMP_W-1], temp_r}) >= $signed({2'b00, target_r, 4'b0000});
    end else begin
      reached = $signed({temp_r[TEMP_W-1], temp_r}) <= $signed({2'b00, target_r, 4'b0000});
    end
    div_neg = diff[TEMP_W+1];
    div_mag = {diff_abs[TEMP_W-1:0], {F{1'b0}}};
  end

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    scan_nxt    = scan_r;
    step_nxt    = step_r;
    target_nxt  = target_r;
    acc_nxt     = acc_r;
    rate_nxt    = rate_r;
    elapsed_nxt = elapsed_r;
    cooler_nxt  = cooler_r;
    active_nxt  = active_r;
    fin_nxt     = fin_r;
    div_start   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          fin_nxt   = 1'b0;
          state_nxt = ST_RESP;
          unique case (op_t'(in_ch.operation))
            OP_START: begin
              scan_nxt  = '0;
              mode_nxt  = MODE_START;
              state_nxt = ST_RD;
            end
            OP_TICK: begin
              if (active_r) begin
                scan_nxt  = step_r;
                mode_nxt  = MODE_CUR;
                state_nxt = ST_RD;
              end
            end
            OP_WRITE, OP_NONE: begin
              state_nxt = ST_RESP;
            end
            default: state_nxt = ST_RESP;
          endcase
        end
      end

      ST_RD: state_nxt = ST_EVAL;

      ST_EVAL: begin
        state_nxt = ST_RESP;
        if (mode_r == MODE_CUR) begin
          if ({1'b0, ent.secs} > elapsed_r) begin
            priority if (sum > ACC_HI) begin
              acc_nxt = ACC_HI[ACC_W-1:0];
            end else if (sum < ACC_LO) begin
              acc_nxt = ACC_LO[ACC_W-1:0];
            end else begin
              acc_nxt = sum[ACC_W-1:0];
            end
            elapsed_nxt = elapsed_inc;
          end else begin
            acc_nxt = {1'b0, target_r, 4'b0000, {F{1'b0}}};
            if (!reached) begin
              elapsed_nxt = elapsed_inc;
            end else if (step_inc == DEPTH_IDX) begin
              active_nxt = 1'b0;
              fin_nxt    = 1'b1;
            end else begin
              scan_nxt  = step_inc;
              mode_nxt  = MODE_ADV;
              state_nxt = ST_RD;
            end
          end
        end else begin
          // Walk the table: apply cooler entries, skip zero targets, stop at done or table end.
          unique case (ent.kind)
            KIND_DONE: begin
              active_nxt = 1'b0;
              fin_nxt    = 1'b1;
            end
            KIND_COOL_ON, KIND_COOL_OFF, KIND_NORMAL: begin
              if (ent.kind == KIND_COOL_ON) begin
                cooler_nxt = 1'b1;
              end else if (ent.kind == KIND_COOL_OFF) begin
                cooler_nxt = 1'b0;
              end
              if (ent.kind == KIND_NORMAL && ent.temp != '0) begin
                step_nxt   = scan_r;
                target_nxt = ent.temp;
                if (mode_r == MODE_START) begin
                  acc_nxt     = {temp_r, {F{1'b0}}};
                  elapsed_nxt = '0;
                  active_nxt  = 1'b1;
                end else begin
                  elapsed_nxt = ELAPSED_W'(1);
                end
                if (mode_r == MODE_ADV && ent.temp == target_r) begin
                  rate_nxt = '0;
                end else if (ent.secs == '0) begin
                  rate_nxt = {diff[TEMP_W:0], {F{1'b0}}};
                end else begin
                  div_start = 1'b1;
                  state_nxt = ST_DIV;
                end
              end else if (scan_r == LAST_IDX) begin
                active_nxt = 1'b0;
                fin_nxt    = 1'b1;
              end else begin
                scan_nxt  = scan_r + IW'(1);
                state_nxt = ST_RD;
              end
            end
            default: state_nxt = ST_RESP;
          endcase
        end
      end

      ST_DIV: begin
        if (div_done) begin
          rate_nxt  = div_quot;
          state_nxt = ST_RESP;
        end
      end

      ST_RESP: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      target_r    <= '0;
      acc_r       <= '0;
      rate_r      <= '0;
      elapsed_r   <= '0;
      cooler_r    <= 1'b0;
      active_r    <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      target_r  <= target_nxt;
      acc_r     <= acc_nxt;
      rate_r    <= rate_nxt;
      elapsed_r <= elapsed_nxt;
      cooler_r  <= cooler_nxt;
      active_r  <= active_nxt;
      fin_r     <= fin_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the scan index, mode, input temperature and result word.
  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    scan_r <= scan_nxt;
    if (in_acc) begin
      temp_r <= in_ch.temperature;
    end
    if (out_load) begin
      out_sp_r   <= acc_r[ACC_W-1:F];
      out_tgt_r  <= {target_r, 4'b0000};
      out_cool_r <= cooler_r;
      out_run_r  <= active_r;
      out_fin_r  <= fin_r;
    end
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.setpoint_out = out_sp_r;
  assign out_ch.target_out   = out_tgt_r;
  assign out_ch.cooler_on    = out_cool_r;
  assign out_ch.running      = out_run_r;
  assign out_ch.finished     = out_fin_r;

endmodule

// ----- hdl/tprs_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tprs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/tprs_div.sv -----
`timescale 1ns / 1ps
// Bit-serial restoring divider for the ramp rate: one quotient bit a cycle.
// Depends on tprs_pkg for the temperature and seconds widths.
module tprs_div import tprs_pkg::*; #(
  parameter int FRAC_BITS = RATE_FRAC_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                negate,
  input  logic [TEMP_W+FRAC_BITS-1:0]         mag,
  input  logic [SECS_W-1:0]                   divisor,
  output logic                                done,
  output logic signed [TEMP_W+FRAC_BITS:0]    quotient
);

  localparam int MAG_W  = TEMP_W + FRAC_BITS;
  localparam int RATE_W = MAG_W + 1;
  localparam int CNT_W  = $clog2(MAG_W + 1);

  logic              busy_r;
  logic              done_r;
  logic              neg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SECS_W-1:0] rem_r;
  logic [SECS_W-1:0] dvs_r;
  logic [MAG_W-1:0]  shf_r;

  logic [SECS_W:0]   trial;
  logic [SECS_W:0]   diff;
  logic              ge;
  logic [SECS_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, shf_r[MAG_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[SECS_W-1:0] : trial[SECS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(MAG_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Dividend shifts out at the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      shf_r <= mag;
      rem_r <= '0;
      dvs_r <= divisor;
      neg_r <= negate;
    end else if (busy_r) begin
      shf_r <= {shf_r[MAG_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? $signed(RATE_W'(0) - {1'b0, shf_r}) : $signed({1'b0, shf_r});

endmodule

// ----- tb/profile_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the thermal profile ramp sequencer: watches both channels,
// models the sequencer status and compares every result word. Needs tprs_pkg, tprs_if.
module profile_checker import tprs_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int FRAC  = RATE_FRAC_DEF
) (
  input  logic clk,
  input  logic rst_n,
  tprs_in_if   in_mon,
  tprs_out_if  out_mon,
  output int   errors,
  output int   pending
);

  localparam longint SP_LO = -16384;
  localparam longint SP_HI = 16383;
  localparam int     ELAPSED_CAP = 511;

  typedef struct packed {
    logic signed [TEMP_W-1:0] setpoint;
    logic [TGT_W-1:0]         target;
    logic                     cooler;
    logic                     running;
    logic                     finished;
  } status_t;

  entry_t             prof [DEPTH];
  int                 step_idx;
  logic [ETEMP_W-1:0] tgt_deg;
  longint             sp_acc;
  longint             rate;
  int                 elapsed;
  logic               cooler;
  logic               active;
  int                 fail_count = 0;
  status_t            status_due [$];

  assign errors = fail_count;

  function automatic longint to_acc(longint v);
    return v * (longint'(1) << FRAC);
  endfunction

  function automatic longint clamp_acc(longint a);
    if (a < to_acc(SP_LO)) return to_acc(SP_LO);
    if (a > to_acc(SP_HI)) return to_acc(SP_HI);
    return a;
  endfunction

  function automatic longint ramp_step(logic [ETEMP_W-1:0] tgt, longint from,
                                       logic [SECS_W-1:0] secs);
    longint diff;
    diff = to_acc(longint'(tgt) * 16 - from);
    if (secs == 0) return diff;
    return diff / longint'(secs);
  endfunction

  // Walk forward, applying cooler entries; DEPTH means done or table end.
  function automatic int seek_step(int from);
    for (int i = from; i < DEPTH; i++) begin
      case (prof[i].kind)
        KIND_DONE:     return DEPTH;
        KIND_COOL_ON:  cooler = 1'b1;
        KIND_COOL_OFF: cooler = 1'b0;
        default: begin
          if (prof[i].temp != 0) return i;
        end
      endcase
    end
    return DEPTH;
  endfunction

  function automatic status_t next_status(op_t op, longint temp, logic [IDX_W-1:0] idx,
                                          logic [KIND_W-1:0] kind,
                                          logic [ETEMP_W-1:0] etemp,
                                          logic [SECS_W-1:0] secs);
    entry_t  cur;
    int      nxt;
    bit      stopped;
    bit      reached;
    longint  tgt16;
    status_t res;
    logic    fin;
    fin = 1'b0;
    stopped = 1'b0;
    case (op)
      OP_WRITE: begin
        if (idx < DEPTH) prof[idx] = {kind, etemp, secs};
      end
      OP_START: begin
        nxt = seek_step(0);
        if (nxt >= DEPTH) begin
          active = 1'b0;
          fin = 1'b1;
        end else begin
          step_idx = nxt;
          tgt_deg = prof[nxt].temp;
          sp_acc = to_acc(temp);
          rate = ramp_step(tgt_deg, temp, prof[nxt].secs);
          elapsed = 0;
          active = 1'b1;
        end
      end
      OP_TICK: begin
        if (active) begin
          cur = prof[step_idx];
          if (int'(cur.secs) > elapsed) begin
            sp_acc = clamp_acc(sp_acc + rate);
          end else begin
            tgt16 = longint'(tgt_deg) * 16;
            reached = (rate >= 0) ? (temp >= tgt16) : (temp <= tgt16);
            sp_acc = to_acc(tgt16);
            if (reached) begin
              nxt = seek_step(step_idx + 1);
              if (nxt >= DEPTH) begin
                active = 1'b0;
                fin = 1'b1;
                stopped = 1'b1;
              end else begin
                step_idx = nxt;
                // equal target keeps the target and stops the ramp
                if (prof[nxt].temp == tgt_deg) begin
                  rate = 0;
                end else begin
                  tgt_deg = prof[nxt].temp;
                  rate = ramp_step(tgt_deg, temp, prof[nxt].secs);
                end
                elapsed = 0;
              end
            end
          end
          if (!stopped && elapsed < ELAPSED_CAP) elapsed++;
        end
      end
      default: ;
    endcase
    res.setpoint = TEMP_W'(sp_acc >>> FRAC);
    res.target   = {tgt_deg, 4'b0000};
    res.cooler   = cooler;
    res.running  = active;
    res.finished = fin;
    return res;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    status_t want;
    if (!rst_n) begin
      step_idx = 0;
      tgt_deg  = '0;
      sp_acc   = 0;
      rate     = 0;
      elapsed  = 0;
      cooler   = 1'b0;
      active   = 1'b0;
      status_due.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        status_due.push_back(next_status(op_t'(in_mon.operation),
                                         longint'(in_mon.temperature),
                                         in_mon.entry_index, in_mon.entry_kind,
                                         in_mon.entry_temp, in_mon.entry_seconds));
      if (out_mon.valid && out_mon.ready) begin
        if (status_due.size() == 0) begin
          $error("result word arrived with nothing outstanding");
          fail_count++;
        end else begin
          want = status_due.pop_front();
          check_field("setpoint_out", int'(want.setpoint), int'(out_mon.setpoint_out));
          check_field("target_out", int'(want.target), int'(out_mon.target_out));
          check_field("cooler_on", int'(want.cooler), int'(out_mon.cooler_on));
          check_field("running", int'(want.running), int'(out_mon.running));
          check_field("finished", int'(want.finished), int'(out_mon.finished));
        end
      end
    end
    pending <= status_due.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Top of the sequencer testbench: clock, reset, stimulus, result back-pressure,
// watchdog and verdict. Needs tprs_pkg, tprs_if, profile_checker and the RTL.
module testbench;
  import tprs_pkg::*;

  localparam int CLK_HALF   = 5;
  localparam int IDLE_LIMIT = 3000;
  localparam int ITEM_GOAL  = 1150;
  localparam int LONG_HOLD  = 400;
  localparam int SETTLE     = 100;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = 15'h4000;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 15'h3FFF;

  logic clk = 1'b0;
  logic rst_n;
  int   errors;
  int   pending;
  int   quiet_cycles = 0;
  int   sent = 0;
  bit   sender_calm = 1'b0;

  tprs_in_if  in_ch ();
  tprs_out_if out_ch ();

  thermal_profile_ramp_sequencer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  profile_checker chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .errors  (errors),
    .pending (pending)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_word(op_t op, logic signed [TEMP_W-1:0] temp, logic [IDX_W-1:0] idx,
                           logic [KIND_W-1:0] kind, logic [ETEMP_W-1:0] etemp,
                           logic [SECS_W-1:0] secs);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.temperature   <= temp;
    in_ch.entry_index   <= idx;
    in_ch.entry_kind    <= kind;
    in_ch.entry_temp    <= etemp;
    in_ch.entry_seconds <= secs;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    if (op != OP_NONE) sent++;
  endtask

  // Unknown operation with random payload.
  task automatic send_none();
    send_word(OP_NONE, TEMP_W'($urandom), IDX_W'($urandom), KIND_W'($urandom),
              ETEMP_W'($urandom), SECS_W'($urandom));
  endtask

  task automatic write_slot(logic [IDX_W-1:0] idx, kind_t kind, logic [ETEMP_W-1:0] etemp,
                            logic [SECS_W-1:0] secs);
    send_word(OP_WRITE, TEMP_W'($urandom), idx, kind, etemp, secs);
  endtask

  task automatic start_profile(logic signed [TEMP_W-1:0] temp);
    send_word(OP_START, temp, IDX_W'($urandom), KIND_W'($urandom), ETEMP_W'($urandom),
              SECS_W'($urandom));
  endtask

  task automatic tick(logic signed [TEMP_W-1:0] temp);
    send_word(OP_TICK, temp, IDX_W'($urandom), KIND_W'($urandom), ETEMP_W'($urandom),
              SECS_W'($urandom));
  endtask

  // Drop valid and hold until every result word has been taken.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    do @(posedge clk); while (pending != 0);
  endtask

  // Extremes push steps forward in either ramp direction.
  function automatic logic signed [TEMP_W-1:0] oven_temp();
    case ($urandom_range(0, 9))
      0, 1, 2: return TEMP_MAX;
      3, 4, 5: return TEMP_MIN;
      default: return TEMP_W'($urandom);
    endcase
  endfunction

  function automatic logic [SECS_W-1:0] step_secs();
    case ($urandom_range(0, 19))
      0:                return SECS_W'($urandom);
      1, 2, 3, 4, 5:    return SECS_W'($urandom_range(5, 20));
      default:          return SECS_W'($urandom_range(0, 4));
    endcase
  endfunction

  function automatic kind_t rand_kind(bit no_done);
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return KIND_NORMAL;
    if (r < 14) return KIND_COOL_OFF;
    if (r < 16) return KIND_COOL_ON;
    return no_done ? KIND_NORMAL : KIND_DONE;
  endfunction

  function automatic logic [ETEMP_W-1:0] step_target(logic [ETEMP_W-1:0] prev);
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return prev;
      3:       return '1;
      default: return ETEMP_W'($urandom);
    endcase
  endfunction

  initial begin
    int                 seq;
    int                 off;
    bit                 no_done;
    logic [ETEMP_W-1:0] last_t;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.operation     <= OP_NONE;
    in_ch.temperature   <= '0;
    in_ch.entry_index   <= '0;
    in_ch.entry_kind    <= '0;
    in_ch.entry_temp    <= '0;
    in_ch.entry_seconds <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle tick, unknown op, a short profile through every entry kind
    tick(TEMP_MAX);
    send_none();
    write_slot(4'd0, KIND_COOL_ON, 10'd0, 8'd0);
    write_slot(4'd1, KIND_NORMAL, 10'd0, 8'd5);
    write_slot(4'd2, KIND_NORMAL, 10'd1, 8'd1);
    write_slot(4'd3, KIND_NORMAL, 10'd1023, 8'd2);
    write_slot(4'd4, KIND_NORMAL, 10'd1023, 8'd0);
    write_slot(4'd5, KIND_COOL_OFF, 10'd1023, 8'd255);
    write_slot(4'd6, KIND_DONE, 10'd512, 8'd128);
    write_slot(4'd15, KIND_NORMAL, 10'd1023, 8'd255);
    start_profile(TEMP_MAX);
    tick(TEMP_MAX);
    tick(TEMP_MIN);
    tick(15'sd0);
    tick(TEMP_MAX);
    tick(15'sd16368);
    tick(15'sd100);
    start_profile(TEMP_MIN);
    tick(-15'sd1);
    start_profile(15'sd5);
    write_slot(4'd0, KIND_DONE, 10'd0, 8'd0);
    start_profile(15'sd77);
    tick(TEMP_MAX);

    // random profiles
    seq = 0;
    last_t = '0;
    while (sent < ITEM_GOAL) begin
      sender_calm = ($urandom_range(0, 3) == 0);
      if (seq % 6 == 5) drain();
      if (seq == 0 || $urandom_range(0, 2) == 0) begin
        off = $urandom_range(0, DEPTH_DEF - 1);
        no_done = ($urandom_range(0, 4) == 0);
        for (int k = 0; k < DEPTH_DEF; k++) begin
          last_t = step_target(last_t);
          write_slot(IDX_W'(k + off), rand_kind(no_done), last_t, step_secs());
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          last_t = step_target(last_t);
          write_slot(IDX_W'($urandom), rand_kind(1'b0), last_t, step_secs());
        end
      end
      start_profile(TEMP_W'($urandom));
      repeat ($urandom_range(4, 40)) begin
        case ($urandom_range(0, 19))
          0:       send_none();
          1:       write_slot(IDX_W'($urandom), rand_kind(1'b0), step_target(last_t),
                              step_secs());
          2:       start_profile(TEMP_W'($urandom));
          default: tick(oven_temp());
        endcase
      end
      seq++;
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side: random stalls, calm stretches and one long hold-off.
  initial begin
    int gap;
    int taken;
    bit calm;
    taken = 0;
    calm = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, 5);
      if (taken == 300) gap = LONG_HOLD;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      taken++;
    end
  end

endmodule

// ----- filelist.f -----
hdl/tprs_pkg.sv
hdl/tprs_if.sv
hdl/tprs_ram.sv
hdl/tprs_div.sv
hdl/thermal_profile_ramp_sequencer_top.sv
tb/profile_checker.sv
tb/testbench.sv
